// ----- rtl/skli_pkg.sv -----
// Shared constants and types for the sorted key list intersection unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package skli_pkg;

    localparam int KEY_W          = 128;
    localparam int HALF_W         = 64;
    localparam int LIST_DEPTH_DEF = 16;
    localparam int MATCH_W        = 5;

    localparam logic [MATCH_W-1:0] MATCH_MAX = 5'd31;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [MATCH_W-1:0] total;
    } t_walk_stat;

endpackage

`default_nettype wire

// ----- rtl/sorted_key_list_intersection_unit.sv -----
// Top level of the sorted key list intersection unit: load control and result register.
// Depends on skli_pkg, skli_key_mem and skli_walker.
`default_nettype none

// Each item carries one 128-bit key of list A and one of list B and is
// stored; items beyond LIST_DEPTH in a set are dropped. The item marked
// last closes the set: the block then stops taking items until the count
// has moved to the result register. It first primes the key store read
// ports and then walks both lists at one pointer step per cycle until
// either list runs out. It then holds the count while an earlier result
// still waits to be taken and hands it to the output register. The walk is
// bounded by the single read port of each key store. The result register
// lets the next set load while a result waits to be taken.
module sorted_key_list_intersection_unit #(
    parameter  int LIST_DEPTH = skli_pkg::LIST_DEPTH_DEF,
    localparam int CW         = $clog2(LIST_DEPTH + 1),
    localparam int IW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [skli_pkg::HALF_W-1:0]  i_a_high,
    input  wire logic [skli_pkg::HALF_W-1:0]  i_a_low,
    input  wire logic [skli_pkg::HALF_W-1:0]  i_b_high,
    input  wire logic [skli_pkg::HALF_W-1:0]  i_b_low,
    input  wire logic                         i_last_pair,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_match_found,
    output logic      [skli_pkg::MATCH_W-1:0] o_match_total
);
    import skli_pkg::*;

    logic               in_accept;
    logic               wr_en;
    logic               start;
    logic [CW-1:0]      len;
    logic [CW-1:0]      r_fill;
    logic [IW-1:0]      a_rd_addr;
    logic [IW-1:0]      b_rd_addr;
    logic [KEY_W-1:0]   a_key;
    logic [KEY_W-1:0]   b_key;
    logic               res_ack;
    t_walk_stat         stat;
    logic               r_out_valid;
    logic               r_match_found;
    logic [MATCH_W-1:0] r_match_total;

    assign o_in_ready = !stat.busy;
    assign in_accept  = i_in_valid && o_in_ready;
    assign wr_en      = in_accept && (r_fill != CW'(LIST_DEPTH));
    assign start      = in_accept && i_last_pair;
    assign len        = wr_en ? r_fill + CW'(1) : r_fill;
    assign res_ack    = stat.done && (!r_out_valid || i_out_ready);

    skli_key_mem #(
        .DEPTH (LIST_DEPTH)
    ) u_mem_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[IW-1:0]),
        .i_wr_data ({i_a_high, i_a_low}),
        .i_rd_addr (a_rd_addr),
        .o_rd_data (a_key)
    );

    skli_key_mem #(
        .DEPTH (LIST_DEPTH)
    ) u_mem_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[IW-1:0]),
        .i_wr_data ({i_b_high, i_b_low}),
        .i_rd_addr (b_rd_addr),
        .o_rd_data (b_key)
    );

    skli_walker #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_len    (len),
        .i_ack    (res_ack),
        .o_stat   (stat),
        .o_a_addr (a_rd_addr),
        .o_b_addr (b_rd_addr),
        .i_a_key  (a_key),
        .i_b_key  (b_key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (start) begin
                r_fill <= '0;
            end else if (wr_en) begin
                r_fill <= r_fill + CW'(1);
            end
            if (res_ack) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ack) begin
            r_match_found <= stat.total != '0;
            r_match_total <= stat.total;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_found = r_match_found;
    assign o_match_total = r_match_total;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(LIST_DEPTH))
        else $error("fill count beyond list depth");

    a_last_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (stat.busy && !o_in_ready && r_fill == '0))
        else $error("last item did not start a walk");

    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid && !i_out_ready)) |-> $past(stat.done))
        else $error("result appeared without a finished walk");

    a_found_matches_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_match_found == (o_match_total != '0)))
        else $error("found flag disagrees with match total");

endmodule

`default_nettype wire

// ----- rtl/skli_key_mem.sv -----
// Key store: one write port, one read port with registered read data.
// Depends on skli_pkg for the key width.
`default_nettype none

module skli_key_mem #(
    parameter  int DEPTH = skli_pkg::LIST_DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [AW-1:0]              i_wr_addr,
    input  wire logic [skli_pkg::KEY_W-1:0] i_wr_data,
    input  wire logic [AW-1:0]              i_rd_addr,
    output logic      [skli_pkg::KEY_W-1:0] o_rd_data
);
    import skli_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/skli_walker.sv -----
// Two-pointer merge walk over the A and B key stores.
// Depends on skli_pkg; drives the read ports of both skli_key_mem instances.
`default_nettype none

module skli_walker #(
    parameter  int LIST_DEPTH = skli_pkg::LIST_DEPTH_DEF,
    localparam int CW         = $clog2(LIST_DEPTH + 1),
    localparam int IW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [CW-1:0]              i_len,
    input  wire logic                       i_ack,
    output skli_pkg::t_walk_stat            o_stat,
    output logic      [IW-1:0]              o_a_addr,
    output logic      [IW-1:0]              o_b_addr,
    input  wire logic [skli_pkg::KEY_W-1:0] i_a_key,
    input  wire logic [skli_pkg::KEY_W-1:0] i_b_key
);
    import skli_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_WALK,
        ST_HOLD
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_j, n_j;
    logic [CW-1:0]      r_len, n_len;
    logic [MATCH_W-1:0] r_cnt, n_cnt;
    logic               b_lt;
    logic               key_eq;

    assign b_lt   = i_b_key < i_a_key;
    assign key_eq = i_b_key == i_a_key;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_len   = r_len;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_PRIME;
                    n_i     = '0;
                    n_j     = '0;
                    n_len   = i_len;
                    n_cnt   = '0;
                end
            end
            ST_PRIME: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (b_lt) begin
                    n_j = r_j + CW'(1);
                    if (n_j == r_len) begin
                        n_state = ST_HOLD;
                    end
                end else begin
                    if (key_eq && r_cnt != MATCH_MAX) begin
                        n_cnt = r_cnt + MATCH_W'(1);
                    end
                    n_i = r_i + CW'(1);
                    if (n_i == r_len) begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (i_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
        end
    end

    assign o_a_addr     = n_i[IW-1:0];
    assign o_b_addr     = n_j[IW-1:0];
    assign o_stat.busy  = r_state != ST_IDLE;
    assign o_stat.done  = r_state == ST_HOLD;
    assign o_stat.total = r_cnt;

endmodule

`default_nettype wire

// ----- tb/sorted_key_list_intersection_unit_checker.sv -----
// Checker for the sorted key list intersection unit: watches both channels, predicts the
// match result of every set and compares it with what the block hands out.
// Depends on skli_pkg for widths and the saturation value of the match count.
`default_nettype none

module sorted_key_list_intersection_unit_checker #(
    parameter int LIST_DEPTH = skli_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_ready,
    input  wire logic [skli_pkg::HALF_W-1:0]  i_a_high,
    input  wire logic [skli_pkg::HALF_W-1:0]  i_a_low,
    input  wire logic [skli_pkg::HALF_W-1:0]  i_b_high,
    input  wire logic [skli_pkg::HALF_W-1:0]  i_b_low,
    input  wire logic                         i_last_pair,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic                         i_match_found,
    input  wire logic [skli_pkg::MATCH_W-1:0] i_match_total,
    output int                                o_pending,
    output int                                o_mismatches
);

    typedef struct packed {
        logic                         found;
        logic [skli_pkg::MATCH_W-1:0] total;
    } t_match_result;

    logic [skli_pkg::KEY_W-1:0]   set_a_keys [LIST_DEPTH];
    logic [skli_pkg::KEY_W-1:0]   set_b_keys [LIST_DEPTH];
    int                           stored_pairs = 0;
    int                           mismatch_total = 0;
    t_match_result                expected_matches [$];
    t_match_result                oldest;
    logic [skli_pkg::MATCH_W-1:0] predicted_total;

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
    end

    function automatic logic [skli_pkg::MATCH_W-1:0] walk_match_count(input int n);
        int hits;
        int j;
        hits = 0;
        j    = 0;
        for (int i = 0; i < n; i++) begin
            while (j < n && set_b_keys[j] < set_a_keys[i])
                j++;
            if (j >= n)
                break;
            if (set_b_keys[j] == set_a_keys[i])
                hits++;
        end
        if (hits > int'(skli_pkg::MATCH_MAX))
            return skli_pkg::MATCH_MAX;
        return skli_pkg::MATCH_W'(hits);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_pairs = 0;
            expected_matches.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_matches.size() == 0) begin
                    report_mismatch("result with no set pending", int'(i_match_total), -1);
                end else begin
                    oldest = expected_matches.pop_front();
                    if (i_match_found !== oldest.found)
                        report_mismatch("match_found", int'(i_match_found), int'(oldest.found));
                    if (i_match_total !== oldest.total)
                        report_mismatch("match_total", int'(i_match_total), int'(oldest.total));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (stored_pairs < LIST_DEPTH) begin
                    set_a_keys[stored_pairs] = {i_a_high, i_a_low};
                    set_b_keys[stored_pairs] = {i_b_high, i_b_low};
                    stored_pairs++;
                end
                if (i_last_pair) begin
                    predicted_total = walk_match_count(stored_pairs);
                    expected_matches.push_back({predicted_total != '0, predicted_total});
                    stored_pairs = 0;
                end
            end
        end
        o_pending    <= expected_matches.size();
        o_mismatches <= mismatch_total;
    end

endmodule

`default_nettype wire

// ----- tb/sorted_key_list_intersection_unit_tb.sv -----
// Testbench top for the sorted key list intersection unit: clock, reset, key list stimulus
// with sender bursts and receiver stalls, and the final verdict.
// Depends on skli_pkg, the block and sorted_key_list_intersection_unit_checker.
`default_nettype none

module sorted_key_list_intersection_unit_tb;

    localparam int DEPTH     = skli_pkg::LIST_DEPTH_DEF;
    localparam int KW        = skli_pkg::KEY_W;
    localparam int HW        = skli_pkg::HALF_W;
    localparam int MAX_SET   = 24;
    localparam int RAND_ITEMS = 650;

    localparam int STYLE_SORTED   = 0;
    localparam int STYLE_UNSORTED = 1;
    localparam int STYLE_REPEATS  = 2;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_ready;
    logic [HW-1:0]                i_a_high    = '0;
    logic [HW-1:0]                i_a_low     = '0;
    logic [HW-1:0]                i_b_high    = '0;
    logic [HW-1:0]                i_b_low     = '0;
    logic                         i_last_pair = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic                         o_match_found;
    logic [skli_pkg::MATCH_W-1:0] o_match_total;

    int pending_results;
    int mismatch_count;

    logic [KW-1:0] a_list [MAX_SET];
    logic [KW-1:0] b_list [MAX_SET];
    logic [HW-1:0] shared_high [4];
    int            items_sent = 0;
    int            burst_left = 0;
    int            stall_mode = 0;
    int            mode_left  = 0;

    sorted_key_list_intersection_unit #(
        .LIST_DEPTH(DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_a_high     (i_a_high),
        .i_a_low      (i_a_low),
        .i_b_high     (i_b_high),
        .i_b_low      (i_b_low),
        .i_last_pair  (i_last_pair),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_match_found(o_match_found),
        .o_match_total(o_match_total)
    );

    sorted_key_list_intersection_unit_checker #(
        .LIST_DEPTH(DEPTH)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_a_high     (i_a_high),
        .i_a_low      (i_a_low),
        .i_b_high     (i_b_high),
        .i_b_low      (i_b_low),
        .i_last_pair  (i_last_pair),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_match_found(o_match_found),
        .i_match_total(o_match_total),
        .o_pending    (pending_results),
        .o_mismatches (mismatch_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 120);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: begin
                i_out_ready <= 1'b1;
            end
            1: begin
                i_out_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                i_out_ready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
            end
        endcase
    end

    function automatic logic [HW-1:0] rand_half();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KW-1:0] rand_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return {shared_high[$urandom_range(0, 3)], rand_half()};
            4:       return {rand_half(), shared_high[$urandom_range(0, 3)]};
            default: return {rand_half(), rand_half()};
        endcase
    endfunction

    task automatic send_pair(input logic [KW-1:0] a_key, input logic [KW-1:0] b_key,
                             input logic last);
        i_in_valid  <= 1'b1;
        i_a_high    <= a_key[KW-1:HW];
        i_a_low     <= a_key[HW-1:0];
        i_b_high    <= b_key[KW-1:HW];
        i_b_low     <= b_key[HW-1:0];
        i_last_pair <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_lists(input int n);
        for (int i = 0; i < n; i++)
            send_pair(a_list[i], b_list[i], i == n - 1);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
    endtask

    task automatic sort_lists(input int n);
        logic [KW-1:0] hold;
        int            j;
        for (int i = 1; i < n; i++) begin
            hold = a_list[i];
            j    = i - 1;
            while (j >= 0 && a_list[j] > hold) begin
                a_list[j + 1] = a_list[j];
                j--;
            end
            a_list[j + 1] = hold;
        end
        for (int i = 1; i < n; i++) begin
            hold = b_list[i];
            j    = i - 1;
            while (j >= 0 && b_list[j] > hold) begin
                b_list[j + 1] = b_list[j];
                j--;
            end
            b_list[j + 1] = hold;
        end
    endtask

    task automatic build_lists(input int n, input int style);
        int pick;
        for (int i = 0; i < n; i++) begin
            if (style == STYLE_REPEATS && i > 0 && $urandom_range(0, 1) == 1)
                a_list[i] = a_list[i - 1];
            else
                a_list[i] = rand_key();
        end
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, n - 1);
            case ($urandom_range(0, 7))
                0, 1, 2, 3: b_list[i] = a_list[pick];
                4:          b_list[i] = a_list[pick] + 1'b1;
                5:          b_list[i] = a_list[pick] - 1'b1;
                default:    b_list[i] = rand_key();
            endcase
        end
        if (style != STYLE_UNSORTED)
            sort_lists(n);
    endtask

    initial begin
        int set_len;
        int style;
        int roll;
        logic drained_mid;

        drained_mid = 1'b0;
        for (int i = 0; i < 4; i++)
            shared_high[i] = rand_half();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        a_list[0] = '0;
        b_list[0] = '0;
        send_lists(1);

        a_list[0] = '1;
        b_list[0] = '0;
        send_lists(1);

        a_list[0] = {{HW{1'b1}}, {HW{1'b0}}};
        a_list[1] = {{HW{1'b1}}, {HW{1'b0}}};
        a_list[2] = '1;
        b_list[0] = {{HW{1'b1}}, {HW{1'b0}}};
        b_list[1] = {{HW{1'b1}}, HW'(1)};
        b_list[2] = '1;
        send_lists(3);

        a_list[0] = KW'(5);
        a_list[1] = KW'(1);
        b_list[0] = KW'(1);
        b_list[1] = KW'(5);
        send_lists(2);

        for (int i = 0; i < DEPTH + 1; i++) begin
            a_list[i] = {HW'(i), ~HW'(i)};
            b_list[i] = {HW'(i), ~HW'(i)};
        end
        send_lists(DEPTH + 1);

        drain_results();

        while (items_sent < RAND_ITEMS + 24) begin
            roll = $urandom_range(0, 19);
            if (roll < 2)
                set_len = $urandom_range(DEPTH + 1, MAX_SET);
            else if (roll < 4)
                set_len = DEPTH;
            else
                set_len = $urandom_range(1, 10);
            roll = $urandom_range(0, 9);
            style = (roll == 0) ? STYLE_UNSORTED : (roll == 1) ? STYLE_REPEATS : STYLE_SORTED;
            build_lists(set_len, style);
            send_lists(set_len);
            if (!drained_mid && items_sent > 350) begin
                drain_results();
                drained_mid = 1'b1;
            end
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("sorted_key_list_intersection_unit verification clean");
        else
            $display("sorted_key_list_intersection_unit verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("sorted_key_list_intersection_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
